FILE: rtl/core/assert_macros.svh
// Assertion macros for the core RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at each rising clock edge, ignored while reset is high.
`define ASSERT_RST(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("core assertion failed");

// Check a property at each rising clock edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) (prop)) \
      else $error("core assertion failed");

`endif

FILE: rtl/core/rpu_pkg.sv
// Shared constants, types and a helper function of the RMSProp update core.
`timescale 1ns / 1ps

package rpu_pkg;

   // Default table depth
   localparam int NUM_PARAMS_DEF = 1024;

   // Field widths
   localparam int IDX_W  = 10;
   localparam int GRAD_W = 32;
   localparam int LR_W   = 24;
   localparam int SF_W   = 25;
   localparam int EPS_W  = 40;
   localparam int R_W    = 64;
   localparam int ROOT_W = 48;
   localparam int D_W    = 49;
   localparam int PROD_W = 56;
   localparam int Q_W    = 32;

   // Pipeline step counts of the root and divide units
   localparam int SQRT_STEPS = 48;
   localparam int DIV_STEPS  = 32;

   // Fixed-point constants
   localparam logic [SF_W-1:0]   ONE_Q24       = 25'h100_0000;
   localparam logic [GRAD_W-1:0] Q24_MAX       = 32'h7FFF_FFFF;
   localparam logic [GRAD_W-1:0] Q24_MIN       = 32'h8000_0000;

   // Register reset values
   localparam logic [LR_W-1:0]  LR_RESET  = 24'd16777;
   localparam logic [SF_W-1:0]  SF_RESET  = 25'd16760439;
   localparam logic [EPS_W-1:0] EPS_RESET = 40'd10995;

   // Register indexes of the configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 40;
   localparam logic [CSR_IDX_W-1:0] CSR_LEARNING_RATE    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SMOOTHING_FACTOR = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_EPSILON_TERM     = 2'd2;

   // Per-item control that rides along the pipeline
   typedef struct packed {
      logic             in_range;
      logic             neg;
      logic             nonzero;
      logic [IDX_W-1:0] idx;
   } item_tag_type;

   // Sideband through the root unit
   typedef struct packed {
      item_tag_type      tag;
      logic [PROD_W-1:0] prod;
   } sqrt_side_type;

   // Result of the divide unit
   typedef struct packed {
      item_tag_type   tag;
      logic           ovf;
      logic           dzero;
      logic [Q_W-1:0] quot;
   } div_result_type;

   // One result item
   typedef struct packed {
      logic [IDX_W-1:0]  idx;
      logic [GRAD_W-1:0] new_param;
      logic [GRAD_W-1:0] step;
   } rsp_item_type;

   // floor(x * a / 2^24) for a up to 2^24, split in two 32x25 products
   function automatic logic [R_W-1:0] mul_q24(input logic [R_W-1:0] x,
                                              input logic [SF_W-1:0] a);
      logic [56:0] hi_p;
      logic [56:0] lo_p;
      hi_p = x[63:32] * a;
      lo_p = x[31:0] * a;
      return 64'({hi_p, 8'd0}) + 64'(lo_p[56:24]);
   endfunction

endpackage

FILE: rtl/core/rpu_store.sv
// Single-port-write, single-port-read state table with write-first read.
`timescale 1ns / 1ps

module rpu_store import rpu_pkg::*; #(
   parameter int WIDTH = R_W,
   parameter int DEPTH = NUM_PARAMS_DEF
) (
   input  logic                                  clock,
   input  logic                                  rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data,
   input  logic                                  wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read; pass a same-edge write straight through
   always_ff @(posedge clock) begin
      if (rd_en) begin
         if (wr_en && (wr_addr == rd_addr)) begin
            rd_data_ff <= wr_data;
         end else begin
            rd_data_ff <= mem[rd_addr];
         end
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/rpu_sqrt.sv
// Pipelined digit-by-digit square root, one result bit per stage.
`timescale 1ns / 1ps

module rpu_sqrt import rpu_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  logic [R_W-1:0]    in_value,
   input  sqrt_side_type     in_side,
   output logic              out_valid,
   output logic [ROOT_W-1:0] out_root,
   output sqrt_side_type     out_side
);

   localparam int REM_W = ROOT_W + 3;

   logic              valid_ff [SQRT_STEPS];
   logic [REM_W-1:0]  rem_ff   [SQRT_STEPS];
   logic [REM_W-1:0]  rem_in   [SQRT_STEPS];
   logic [ROOT_W-1:0] root_ff  [SQRT_STEPS];
   logic [ROOT_W-1:0] root_in  [SQRT_STEPS];
   logic [R_W-1:0]    rest_ff  [SQRT_STEPS];
   logic [R_W-1:0]    rest_in  [SQRT_STEPS];
   sqrt_side_type     side_ff  [SQRT_STEPS];
   sqrt_side_type     side_in  [SQRT_STEPS];

   logic [REM_W-1:0]  rem_src  [SQRT_STEPS];
   logic [ROOT_W-1:0] root_src [SQRT_STEPS];
   logic [R_W-1:0]    rest_src [SQRT_STEPS];
   logic [REM_W-1:0]  remx     [SQRT_STEPS];
   logic [REM_W-1:0]  trial    [SQRT_STEPS];

   // One root bit per stage: bring down a bit pair, try root*4+1
   always_comb begin
      for (int k = 0; k < SQRT_STEPS; k++) begin
         if (k == 0) begin
            rem_src[k]  = '0;
            root_src[k] = '0;
            rest_src[k] = in_value;
            side_in[k]  = in_side;
         end else begin
            rem_src[k]  = rem_ff[k-1];
            root_src[k] = root_ff[k-1];
            rest_src[k] = rest_ff[k-1];
            side_in[k]  = side_ff[k-1];
         end
         remx[k]  = {rem_src[k][REM_W-3:0], rest_src[k][R_W-1 -: 2]};
         trial[k] = {1'b0, root_src[k], 2'b01};
         if (remx[k] >= trial[k]) begin
            rem_in[k]  = remx[k] - trial[k];
            root_in[k] = {root_src[k][ROOT_W-2:0], 1'b1};
         end else begin
            rem_in[k]  = remx[k];
            root_in[k] = {root_src[k][ROOT_W-2:0], 1'b0};
         end
         rest_in[k] = {rest_src[k][R_W-3:0], 2'b00};
      end
   end

   // Advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < SQRT_STEPS; k++) begin
            valid_ff[k] <= 1'b0;
         end
      end else if (en) begin
         for (int k = 0; k < SQRT_STEPS; k++) begin
            valid_ff[k] <= (k == 0) ? in_valid : valid_ff[k-1];
         end
      end
   end

   // Advance data
   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < SQRT_STEPS; k++) begin
            rem_ff[k]  <= rem_in[k];
            root_ff[k] <= root_in[k];
            rest_ff[k] <= rest_in[k];
            side_ff[k] <= side_in[k];
         end
      end
   end

   assign out_valid = valid_ff[SQRT_STEPS-1];
   assign out_root  = root_ff[SQRT_STEPS-1];
   assign out_side  = side_ff[SQRT_STEPS-1];

endmodule

FILE: rtl/core/rpu_div.sv
// Pipelined restoring divider, overflow check then one quotient bit per stage.
`timescale 1ns / 1ps

module rpu_div import rpu_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  logic [PROD_W-1:0] in_num,
   input  logic [D_W-1:0]    in_den,
   input  item_tag_type      in_tag,
   output logic              out_valid,
   output div_result_type    out_result
);

   localparam int STAGES = DIV_STEPS + 1;
   localparam int HI_W   = PROD_W - 16;

   logic           valid_ff [STAGES];
   logic [D_W-1:0] rem_ff   [STAGES];
   logic [D_W-1:0] rem_in   [STAGES];
   logic [Q_W-1:0] low_ff   [STAGES];
   logic [Q_W-1:0] low_in   [STAGES];
   logic [D_W-1:0] den_ff   [STAGES];
   logic [D_W-1:0] den_in   [STAGES];
   div_result_type res_ff   [STAGES];
   div_result_type res_in   [STAGES];
   logic [D_W:0]   remx     [STAGES];
   logic           ge       [STAGES];

   // Overflow check on the top bits, then one restoring step per stage
   always_comb begin
      remx[0]              = '0;
      ge[0]                = 1'b0;
      rem_in[0]            = {{(D_W-HI_W){1'b0}}, in_num[PROD_W-1:16]};
      low_in[0]            = {in_num[15:0], 16'd0};
      den_in[0]            = in_den;
      res_in[0].tag        = in_tag;
      res_in[0].dzero      = (in_den == '0);
      res_in[0].ovf        = ({{(D_W-HI_W){1'b0}}, in_num[PROD_W-1:16]} >= in_den);
      res_in[0].quot       = '0;
      for (int k = 1; k < STAGES; k++) begin
         remx[k]   = {rem_ff[k-1], low_ff[k-1][Q_W-1]};
         ge[k]     = (remx[k] >= {1'b0, den_ff[k-1]});
         if (ge[k]) begin
            rem_in[k] = D_W'(remx[k] - {1'b0, den_ff[k-1]});
         end else begin
            rem_in[k] = remx[k][D_W-1:0];
         end
         low_in[k]      = {low_ff[k-1][Q_W-2:0], 1'b0};
         den_in[k]      = den_ff[k-1];
         res_in[k]      = res_ff[k-1];
         res_in[k].quot = {res_ff[k-1].quot[Q_W-2:0], ge[k]};
      end
   end

   // Advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < STAGES; k++) begin
            valid_ff[k] <= 1'b0;
         end
      end else if (en) begin
         for (int k = 0; k < STAGES; k++) begin
            valid_ff[k] <= (k == 0) ? in_valid : valid_ff[k-1];
         end
      end
   end

   // Advance data
   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < STAGES; k++) begin
            rem_ff[k] <= rem_in[k];
            low_ff[k] <= low_in[k];
            den_ff[k] <= den_in[k];
            res_ff[k] <= res_in[k];
         end
      end
   end

   assign out_valid  = valid_ff[STAGES-1];
   assign out_result = res_ff[STAGES-1];

endmodule

FILE: rtl/core/rmsprop_parameter_update_core.sv
// RMSProp update core: per-index mean square and parameter tables, update pipeline.
//
// Usage: each item on the req_ channel names a parameter and carries its
// gradient (signed Q8.24). The core updates that parameter's running mean
// square and value and returns one item on the rsp_ channel with the index,
// the new parameter and the step taken (both signed Q8.24, saturated).
// Registers are written on the csr_ channel (index 0 learning rate,
// 1 smoothing factor, 2 epsilon); csr_ready is always high; write them only
// while no item is in flight.
// Throughput is one item per cycle while no stall holds the pipeline, repeated
// indices included: both tables are read and written around an update loop
// with write-first read. From acceptance to rsp_valid an item passes 48 root
// stages, 33 divider stages, six other stages and the output register.
// Reset: registers take their defaults, then both tables are cleared one
// entry per cycle with req_ready low.
// When the receiver stalls, one more item is taken into a skid register;
// after that the whole pipeline holds with req_ready low.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rmsprop_parameter_update_core import rpu_pkg::*; #(
   parameter int NUM_PARAMS = NUM_PARAMS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [IDX_W-1:0]         req_param_index,
   input  logic signed [GRAD_W-1:0] req_grad_value,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [IDX_W-1:0]         rsp_out_index,
   output logic signed [GRAD_W-1:0] rsp_new_param,
   output logic signed [GRAD_W-1:0] rsp_step_value,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic [CSR_DATA_W-1:0]    csr_wdata
);

   localparam int ADDR_W = (NUM_PARAMS > 1) ? $clog2(NUM_PARAMS) : 1;
   localparam logic [31:0] NUM_LIMIT = 32'(NUM_PARAMS);
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(NUM_PARAMS - 1);

   // Configuration registers
   logic [LR_W-1:0]  lr_ff;
   logic [SF_W-1:0]  sf_ff;
   logic [EPS_W-1:0] eps_ff;
   logic [SF_W-1:0]  s_eff;
   logic [SF_W-1:0]  one_minus_s;

   // Table clearing
   logic              clr_busy_ff;
   logic [ADDR_W-1:0] clr_addr_ff;

   // Pipeline control
   logic en;

   // Front and back stages
   logic              v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff;
   item_tag_type      tag_in;
   item_tag_type      tag1_ff, tag2_ff, tag3_ff, tag5_ff, tag6_ff;
   logic [GRAD_W-1:0] mag_in;
   logic [GRAD_W-1:0] mag1_ff;
   logic [R_W-1:0]    g2_in, g2_ff;
   logic [PROD_W-1:0] prod_in, prod2_ff, prod3_ff, prod5_ff;
   logic [R_W-1:0]    gterm3_ff;
   logic [R_W-1:0]    r_rd;
   logic [R_W-1:0]    r_new;
   logic [R_W-1:0]    r4_ff;
   sqrt_side_type     side4_ff;

   // Root, denominator and divide
   logic              sq_valid;
   logic [ROOT_W-1:0] sq_root;
   sqrt_side_type     sq_side;
   logic [D_W-1:0]    d5_ff;
   logic              dv_valid;
   div_result_type    dv_res;

   // Step and parameter update
   logic              sat_w;
   logic [Q_W-1:0]    quot_w;
   logic [GRAD_W-1:0] lim_w;
   logic [GRAD_W-1:0] step_in, step6_ff;
   logic [GRAD_W-1:0] p_rd;
   logic [GRAD_W:0]   p_diff;
   logic [GRAD_W-1:0] p_new;

   // Table ports
   logic              r_we, p_we;
   logic [ADDR_W-1:0] r_waddr, p_waddr;
   logic [R_W-1:0]    r_wdata;
   logic [GRAD_W-1:0] p_wdata;

   // Output and skid registers
   rsp_item_type new_item;
   rsp_item_type out_ff, skid_ff;
   logic         out_valid_ff, skid_valid_ff;

   // Configuration writes
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         lr_ff  <= LR_RESET;
         sf_ff  <= SF_RESET;
         eps_ff <= EPS_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_LEARNING_RATE: begin
               lr_ff <= csr_wdata[LR_W-1:0];
            end
            CSR_SMOOTHING_FACTOR: begin
               sf_ff <= csr_wdata[SF_W-1:0];
            end
            CSR_EPSILON_TERM: begin
               eps_ff <= csr_wdata[EPS_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // Clamp smoothing at one
   assign s_eff       = (sf_ff > ONE_Q24) ? ONE_Q24 : sf_ff;
   assign one_minus_s = ONE_Q24 - s_eff;

   // Sweep both tables to zero after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else if (clr_busy_ff) begin
         if (clr_addr_ff == LAST_ADDR) begin
            clr_busy_ff <= 1'b0;
         end else begin
            clr_addr_ff <= clr_addr_ff + 1'b1;
         end
      end
   end

   // Hold the pipeline while the skid register is full
   assign en        = !skid_valid_ff;
   assign req_ready = en && !clr_busy_ff;

   // Take the item apart: magnitude, sign, range
   assign mag_in          = req_grad_value[GRAD_W-1] ? (32'd0 - $unsigned(req_grad_value))
                                                     : $unsigned(req_grad_value);
   assign tag_in.in_range = ({22'd0, req_param_index} < NUM_LIMIT);
   assign tag_in.neg      = req_grad_value[GRAD_W-1];
   assign tag_in.nonzero  = (req_grad_value != '0);
   assign tag_in.idx      = req_param_index;

   // Square and scaled gradient
   assign g2_in   = mag1_ff * mag1_ff;
   assign prod_in = lr_ff * mag1_ff;

   // Mean square update loop on the table read
   assign r_new = gterm3_ff + mul_q24(r_rd, s_eff);

   // Valid bits of the front and back stages
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req_valid && req_ready;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= sq_valid;
         v6_ff <= dv_valid;
      end
   end

   // Advance front and back stage data
   always_ff @(posedge clock) begin
      if (en) begin
         tag1_ff       <= tag_in;
         mag1_ff       <= mag_in;
         tag2_ff       <= tag1_ff;
         g2_ff         <= g2_in;
         prod2_ff      <= prod_in;
         tag3_ff       <= tag2_ff;
         gterm3_ff     <= mul_q24(g2_ff, one_minus_s);
         prod3_ff      <= prod2_ff;
         r4_ff         <= r_new;
         side4_ff.tag  <= tag3_ff;
         side4_ff.prod <= prod3_ff;
         d5_ff         <= {1'b0, sq_root} + {{(D_W-EPS_W){1'b0}}, eps_ff};
         tag5_ff       <= sq_side.tag;
         prod5_ff      <= sq_side.prod;
         tag6_ff       <= dv_res.tag;
         step6_ff      <= step_in;
      end
   end

   // Mean square table
   assign r_we    = clr_busy_ff || (en && v3_ff && tag3_ff.in_range);
   assign r_waddr = clr_busy_ff ? clr_addr_ff : ADDR_W'(tag3_ff.idx);
   assign r_wdata = clr_busy_ff ? '0 : r_new;

   rpu_store #(
      .WIDTH (R_W),
      .DEPTH (NUM_PARAMS)
   ) u_r_store (
      .clock   (clock),
      .rd_en   (en),
      .rd_addr (ADDR_W'(tag2_ff.idx)),
      .rd_data (r_rd),
      .wr_en   (r_we),
      .wr_addr (r_waddr),
      .wr_data (r_wdata)
   );

   // Root of the mean square in Q8.40
   rpu_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (v4_ff),
      .in_value  (r4_ff),
      .in_side   (side4_ff),
      .out_valid (sq_valid),
      .out_root  (sq_root),
      .out_side  (sq_side)
   );

   // Step magnitude: eta*|g|*2^16 / (root + eps)
   rpu_div u_div (
      .clock      (clock),
      .reset      (reset),
      .en         (en),
      .in_valid   (v5_ff),
      .in_num     (prod5_ff),
      .in_den     (d5_ff),
      .in_tag     (tag5_ff),
      .out_valid  (dv_valid),
      .out_result (dv_res)
   );

   // Saturate the step and give it the sign opposite to the gradient;
   // a zero denominator leaves no quotient, only saturation or zero; an out-of-range index gives a zero step
   always_comb begin
      sat_w  = dv_res.dzero ? dv_res.tag.nonzero : dv_res.ovf;
      quot_w = dv_res.dzero ? '0 : dv_res.quot;
      if (dv_res.tag.neg) begin
         lim_w   = (sat_w || (quot_w > Q24_MAX)) ? Q24_MAX : quot_w;
         step_in = lim_w;
      end else begin
         lim_w   = (sat_w || (quot_w > Q24_MIN)) ? Q24_MIN : quot_w;
         step_in = 32'd0 - lim_w;
      end
      if (!dv_res.tag.in_range) begin
         step_in = '0;
      end
   end

   // Parameter update loop on the table read, saturated
   assign p_diff = {p_rd[GRAD_W-1], p_rd} - {step6_ff[GRAD_W-1], step6_ff};
   always_comb begin
      if (p_diff[GRAD_W] != p_diff[GRAD_W-1]) begin
         p_new = p_diff[GRAD_W] ? Q24_MIN : Q24_MAX;
      end else begin
         p_new = p_diff[GRAD_W-1:0];
      end
   end

   // Parameter table
   assign p_we    = clr_busy_ff || (en && v6_ff && tag6_ff.in_range);
   assign p_waddr = clr_busy_ff ? clr_addr_ff : ADDR_W'(tag6_ff.idx);
   assign p_wdata = clr_busy_ff ? '0 : p_new;

   rpu_store #(
      .WIDTH (GRAD_W),
      .DEPTH (NUM_PARAMS)
   ) u_p_store (
      .clock   (clock),
      .rd_en   (en),
      .rd_addr (ADDR_W'(dv_res.tag.idx)),
      .rd_data (p_rd),
      .wr_en   (p_we),
      .wr_addr (p_waddr),
      .wr_data (p_wdata)
   );

   // Result item; out-of-range indexes return zeros
   assign new_item.idx       = tag6_ff.idx;
   assign new_item.new_param = tag6_ff.in_range ? p_new : '0;
   assign new_item.step      = step6_ff;

   // Output register with skid: drain skid first, else take the new item
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (rsp_ready) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (!out_valid_ff || rsp_ready) begin
         out_valid_ff <= v6_ff;
      end else if (v6_ff) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (rsp_ready) begin
            out_ff <= skid_ff;
         end
      end else if (!out_valid_ff || rsp_ready) begin
         out_ff <= new_item;
      end else begin
         skid_ff <= new_item;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_out_index  = out_ff.idx;
   assign rsp_new_param  = out_ff.new_param;
   assign rsp_step_value = out_ff.step;

   // A full skid register always sits behind a full output register
   `ASSERT_RST(a_skid_behind_out, clock, reset, skid_valid_ff |-> out_valid_ff)
   // Draining the skid register frees it, as no new item may enter meanwhile
   `ASSERT_RST(a_skid_drains, clock, reset, (skid_valid_ff && rsp_ready) |=> !skid_valid_ff)
   // No item is in flight or delivered while the tables are being cleared
   `ASSERT_RST(a_clear_empty, clock, reset, clr_busy_ff |-> (!v1_ff && !rsp_valid))

endmodule
